[hw/rtl/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// Types, segment codes and digit decode shared by the formatter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  // Segment patterns of the LCD field.
  localparam logic [7:0] SegMinus   = 8'h04;
  localparam logic [7:0] SegLeadOne = 8'h08;
  localparam logic [7:0] SegPoint   = 8'h08;
  localparam logic [7:0] SegUnitBit = 8'h08;
  localparam logic [7:0] SegH       = 8'h67;
  localparam logic [7:0] SegI       = 8'h20;
  localparam logic [7:0] SegL       = 8'hE0;
  localparam logic [7:0] SegO       = 8'hA6;
  localparam logic [7:0] SegZero    = 8'hF3;

  // Display limits, in tenths.
  localparam int HiLimit     = 19995;
  localparam int LoLimit     = -19995;
  localparam int TenthsLimit = 1995;

  // What the field shows.
  typedef enum logic [1:0] {
    KIND_NUM = 2'd0,
    KIND_HI  = 2'd1,
    KIND_LO  = 2'd2
  } kind_e;

  // Handoff from the magnitude stage to the digit stage.
  typedef struct packed {
    kind_e       kind;
    logic        neg;
    logic        point;
    logic [10:0] shown;
  } stage_t;

  function automatic logic [7:0] seg_digit(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'hF3;
      4'd1:    s = 8'h03;
      4'd2:    s = 8'hB5;
      4'd3:    s = 8'h97;
      4'd4:    s = 8'h47;
      4'd5:    s = 8'hD6;
      4'd6:    s = 8'hF6;
      4'd7:    s = 8'h13;
      4'd8:    s = 8'hF7;
      4'd9:    s = 8'hD7;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tts_digits.sv]
// ----------------------------------------------------------------------------
// tts_digits
// Splits the shown value into digits and builds the three segment bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_digits import tts_pkg::*; (
  input  var stage_t     stage_i,
  output logic [7:0]     lead_o,
  output logic [7:0]     mid_o,
  output logic [7:0]     last_o
);

  logic [23:0] p10;
  logic [23:0] p100;
  logic [7:0]  q10;
  logic [4:0]  q100;
  logic [10:0] units_w;
  logic [7:0]  tens_w;
  logic [4:0]  hund_w;
  logic [3:0]  units;
  logic [3:0]  tens;
  logic [3:0]  hund;

  // Reciprocal multiplies; exact for shown values up to 2000.
  assign p10  = 24'(stage_i.shown) * 24'd6554;
  assign p100 = 24'(stage_i.shown) * 24'd5243;
  assign q10  = p10[23:16];
  assign q100 = p100[23:19];

  assign units_w = stage_i.shown - 11'(q10) * 11'd10;
  assign tens_w  = q10 - 8'(q100) * 8'd10;
  assign units   = units_w[3:0];
  assign tens    = tens_w[3:0];

  always_comb begin
    if (q100 >= 5'd20) begin
      hund_w = q100 - 5'd20;
    end else if (q100 >= 5'd10) begin
      hund_w = q100 - 5'd10;
    end else begin
      hund_w = q100;
    end
  end
  assign hund = hund_w[3:0];

  always_comb begin
    lead_o = 8'h00;
    mid_o  = 8'h00;
    last_o = 8'h00;
    unique case (stage_i.kind)
      KIND_HI: begin
        lead_o = SegH;
        mid_o  = SegI;
      end
      KIND_LO: begin
        lead_o = SegL;
        mid_o  = SegO;
      end
      KIND_NUM: begin
        if (stage_i.neg) begin
          lead_o = SegMinus;
        end
        if (stage_i.shown > 11'd999) begin
          lead_o = lead_o | SegLeadOne;
        end
        if (stage_i.shown > 11'd99) begin
          lead_o = lead_o | seg_digit(hund);
        end
        mid_o = stage_i.point ? SegPoint : 8'h00;
        if (stage_i.shown > 11'd9) begin
          mid_o = mid_o | seg_digit(tens);
        end else begin
          mid_o = mid_o | SegZero;
        end
        last_o = seg_digit(units) & ~SegUnitBit;
      end
      default: begin
        lead_o = 8'h00;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/tenths_to_seven_segment_formatter.sv]
// ----------------------------------------------------------------------------
// tenths_to_seven_segment_formatter
// Turns a signed reading in tenths into the three segment bytes of an LCD.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Payload
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tdata[15:0] = value_tenths (signed)
//  m_axis   | out       | tdata[7:0] lead, [15:8] mid, [23:16] last segments
//
// The block is a three-register pipeline: input register, magnitude and
// rounding register, and result register. One transaction is accepted per
// clock unless a stalled output has filled the pipeline; each result reaches
// m_axis through the magnitude and rounding register and the result register.
// Every stage moves on when the stage after it is empty or emptying, so a
// stalled output fills the pipeline bubbles before the input stalls.
// Reset clears the valid bits only; data registers carry no reset.
`default_nettype none

module tenths_to_seven_segment_formatter import tts_pkg::*; (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        s_axis_tvalid,
  output logic            s_axis_tready,
  input  var logic [15:0] s_axis_tdata,   // [15:0] value_tenths
  output logic            m_axis_tvalid,
  input  var logic        m_axis_tready,
  output logic [23:0]     m_axis_tdata    // [7:0] lead, [15:8] mid, [23:16] last
);

  // Stage valid bits and per-stage advance enables.
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3 = !v3_q || m_axis_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= s_axis_tvalid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Input register.
  logic signed [15:0] value_q;

  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid) begin
      value_q <= s_axis_tdata;
    end
  end

  // First stage: range check, magnitude, and rounding to whole units outside tenths mode.
  logic        neg;
  logic [15:0] mag_full;
  logic [14:0] mag;
  logic [14:0] rnd;
  logic [30:0] prod;
  stage_t      stage_d, stage_q;

  assign neg      = value_q < 16'sd0;
  assign mag_full = neg ? 16'(-value_q) : 16'(value_q);
  assign mag      = mag_full[14:0];
  assign rnd      = mag + 15'd5;
  // Multiply by 2^19/10; exact for sums up to 20000.
  assign prod     = 31'(rnd) * 31'd52429;

  always_comb begin
    stage_d.neg   = neg;
    stage_d.point = 1'b0;
    stage_d.shown = 11'd0;
    if (value_q > 16'(HiLimit)) begin
      stage_d.kind = KIND_HI;
    end else if (value_q < 16'(LoLimit)) begin
      stage_d.kind = KIND_LO;
    end else begin
      stage_d.kind = KIND_NUM;
      if (mag > 15'(TenthsLimit)) begin
        stage_d.shown = prod[29:19];
      end else begin
        // Tenths mode: shown as is, with the decimal point.
        stage_d.point = 1'b1;
        stage_d.shown = mag[10:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      stage_q <= stage_d;
    end
  end

  // Second stage: digit split and segment decode.
  logic [7:0] lead_d, mid_d, last_d;
  logic [23:0] result_q;

  tts_digits u_digits (
    .stage_i (stage_q),
    .lead_o  (lead_d),
    .mid_o   (mid_d),
    .last_o  (last_d)
  );

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      result_q <= {last_d, mid_d, lead_d};
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = result_q;

endmodule

`default_nettype wire

[tb/tb_tenths_to_seven_segment_formatter.sv]
// ----------------------------------------------------------------------------
// tb_tenths_to_seven_segment_formatter
// Self-checking bench for the tenths-to-seven-segment formatter. Readings go
// in over the input stream with random gaps, and the output stream is stalled
// at random. Every result is checked field by field against a local
// prediction of the three segment bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tenths_to_seven_segment_formatter;
  import tts_pkg::*;

  // The run is stopped here if the pipeline ever stops moving.
  localparam int unsigned CycleLimit = 400000;
  // The number of random readings that follow the directed list.
  localparam int RandomReadings = 1600;
  // The number of cycles to wait once the last result has arrived.
  localparam int DrainCycles = 10;

  // One result, laid out as on m_axis_tdata with lead in the lowest byte.
  typedef struct packed {
    logic [7:0] last;
    logic [7:0] mid;
    logic [7:0] lead;
  } seg_word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;     // [15:0] value_tenths
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [7:0] lead, [15:8] mid, [23:16] last

  logic signed [15:0] pending_readings[$];
  seg_word_t          expected_segments[$];
  int                 error_count = 0;
  int unsigned        cycle_count = 0;

  // When this is set, both sides run without any gaps.
  bit burst_mode = 1'b0;

  tenths_to_seven_segment_formatter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Segment pattern of one decimal digit on the LCD.
  function automatic logic [7:0] digit_glyph(input int unsigned digit);
    logic [7:0] glyph;
    case (digit)
      0:       glyph = 8'hF3;
      1:       glyph = 8'h03;
      2:       glyph = 8'hB5;
      3:       glyph = 8'h97;
      4:       glyph = 8'h47;
      5:       glyph = 8'hD6;
      6:       glyph = 8'hF6;
      7:       glyph = 8'h13;
      8:       glyph = 8'hF7;
      default: glyph = 8'hD7;
    endcase
    return glyph;
  endfunction

  // Predicts the three segment bytes that one reading in tenths should light.
  function automatic seg_word_t format_reading(input logic signed [15:0] reading);
    int          value;
    bit          negative;
    int unsigned magnitude;
    int unsigned shown;
    seg_word_t   word;
    value = reading;
    word  = '0;
    if (value > HiLimit) begin
      word.lead = SegH;
      word.mid  = SegI;
    end else if (value < LoLimit) begin
      word.lead = SegL;
      word.mid  = SegO;
    end else begin
      negative  = value < 0;
      magnitude = negative ? -value : value;
      // Large magnitudes drop the tenths and round half up to whole units.
      // The top limit rounds to 2000 and reads as 1000 on the display.
      if (magnitude > TenthsLimit) begin
        shown = (magnitude + 5) / 10;
      end else begin
        shown    = magnitude;
        word.mid = SegPoint;
      end
      if (negative) word.lead = SegMinus;
      if (shown > 999) word.lead |= SegLeadOne;
      // The hundreds digit is blank for small values.
      if (shown > 99) word.lead |= digit_glyph((shown / 100) % 10);
      // A single digit gets a forced leading zero in the tens position.
      if (shown > 9) begin
        word.mid |= digit_glyph((shown / 10) % 10);
      end else begin
        word.mid |= SegZero;
      end
      // The unit symbol bit of the last byte is kept clear.
      word.last = digit_glyph(shown % 10) & ~SegUnitBit;
    end
    return word;
  endfunction

  // Gap length before the next transaction: mostly none or short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Random reading, weighted toward the interesting ranges of the display.
  function automatic logic signed [15:0] pick_reading();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return 16'($urandom_range(0, 2 * TenthsLimit) - TenthsLimit);
    if (roll < 65) return 16'($urandom_range(0, 2 * HiLimit) - HiLimit);
    if (roll < 75) return 16'(HiLimit + $urandom_range(0, 20) - 10);
    if (roll < 85) return 16'(LoLimit + $urandom_range(0, 20) - 10);
    if (roll < 90) return 16'(TenthsLimit + $urandom_range(0, 20) - 10);
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // Input driver. A new reading is put on the bus only when the previous
  // transaction completed at this edge or the bus was idle.
  int input_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      input_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_segments.push_back(format_reading(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (input_gap > 0) begin
          input_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_readings.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_readings.pop_front();
          input_gap = pick_gap();
          // Now and then switch between gapped traffic and full-rate bursts.
          if ($urandom_range(0, 99) < 2) burst_mode = ~burst_mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output back-pressure: tready drops for random stretches.
  int stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!burst_mode && $urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  // Monitor. Each output transaction is compared with the oldest prediction.
  always @(posedge clk_i) begin
    seg_word_t got;
    seg_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_segments.size() == 0) begin
        $display("%0t: result with nothing expected: %06h", $time, got);
        error_count++;
      end else begin
        want = expected_segments.pop_front();
        if (got.lead !== want.lead) begin
          $display("%0t: lead_segments expected %02h actual %02h",
                   $time, want.lead, got.lead);
          error_count++;
        end
        if (got.mid !== want.mid) begin
          $display("%0t: mid_segments expected %02h actual %02h",
                   $time, want.mid, got.mid);
          error_count++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last_segments expected %02h actual %02h",
                   $time, want.last, got.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog against a hung pipeline.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    // Directed readings: zero, both ends of the tenths mode, the rounding
    // boundary, both display limits and the ends of the input range.
    logic signed [15:0] directed[] = '{
      16'sd0, 16'sd1, -16'sd1, 16'sd9, 16'sd10, 16'sd99, 16'sd100,
      16'sd999, 16'sd1000, 16'sd1995, 16'sd1996, -16'sd1995, -16'sd1996,
      16'sd2004, 16'sd2005, 16'sd19994, 16'sd19995, 16'sd19996,
      -16'sd19994, -16'sd19995, -16'sd19996, 16'sd32767, -16'sd32768,
      16'sd12345, -16'sd5
    };
    foreach (directed[i]) pending_readings.push_back(directed[i]);
    for (int i = 0; i < RandomReadings; i++) pending_readings.push_back(pick_reading());

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last input transaction, then for every result.
    while (pending_readings.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_segments.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
